// ===== hw/rtl/simon_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Simon 128/256 package
// Shared constants, the controller-to-datapath command type and the round
// and key schedule helpers.
// ----------------------------------------------------------------------------
package simon_pkg;

    localparam int unsigned WORD_W  = 64;
    localparam int unsigned ROUND_W = 7;
    localparam int unsigned Z_LEN   = 62;
    localparam int unsigned Z_IDX_W = 6;
    localparam int unsigned ADDR_W  = 3;
    localparam int unsigned DATA_W  = 32;

    localparam logic [ROUND_W-1:0] ROUND_COUNT_RESET = 7'd72;

    // register index sits above the byte offset bits
    localparam logic REG_ROUND_COUNT = 1'b0;

    localparam logic [WORD_W-1:0] SIMON_C = 64'hffff_ffff_ffff_fffc;

    // z4 sequence, element 0 leftmost
    localparam logic [0:Z_LEN-1] Z4_SEQ =
        62'b1101000111_1001101011_0110001000_0001011100_0011001010_0100111011_11;

    localparam logic [Z_IDX_W-1:0] Z_IDX_LAST = 6'd61;

    typedef logic [WORD_W-1:0] t_word;

    typedef struct packed {
        logic load;
        logic step;
        logic publish;
    } t_dp_cmd;

    // (rol 1 & rol 8) ^ rol 2
    function automatic t_word simon_f(input t_word x);
        return ({x[62:0], x[63]} & {x[55:0], x[63:56]}) ^ {x[61:0], x[63:62]};
    endfunction

    // next key from k[i], k[i+1], k[i+3] and the z bit of round i
    function automatic t_word simon_key_next(input t_word k0, input t_word k1,
                                             input t_word k3, input logic z);
        t_word t;
        t = {k3[2:0], k3[63:3]} ^ k1;
        return k0 ^ t ^ {t[0], t[63:1]} ^ SIMON_C ^ {{(WORD_W-1){1'b0}}, z};
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/simon_128_256_encrypt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Simon 128/256 encryption engine
// Encrypts one 128-bit block under a 256-bit key per input beat.
//
// Input channel: i_in_valid / o_in_stall with plaintext words and four key
// words. Output channel: o_out_valid / i_out_stall with ciphertext words.
// A beat moves at a clock edge where valid is high and stall is low.
// The APB port holds round_count at address 0 (7 bits, reset 72).
//
// One round unit runs one round per cycle. A block with N rounds enters
// the output register after its N rounds, and the next block can be taken
// on that same edge, so the core finishes one block before it takes the
// next. The round loop sets how often a block can be taken.
// The output register parts the channels: a stalled receiver holds the
// result, the finished block waits in the core, and further input stalls.
// Reset empties both channels and restores round_count to 72.
// ----------------------------------------------------------------------------
module simon_128_256_encrypt
    import simon_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire t_word             i_plain_x,
    input  wire t_word             i_plain_y,
    input  wire t_word             i_key_word_0,
    input  wire t_word             i_key_word_1,
    input  wire t_word             i_key_word_2,
    input  wire t_word             i_key_word_3,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output t_word                  o_cipher_x,
    output t_word                  o_cipher_y
);

    logic [ROUND_W-1:0] r_round_count;
    logic               reg_sel;
    t_dp_cmd            cmd;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[ADDR_W-1] == REG_ROUND_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_round_count <= ROUND_COUNT_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_round_count <= pwdata[ROUND_W-1:0];
        end
    end

    assign prdata = reg_sel ? {{(DATA_W-ROUND_W){1'b0}}, r_round_count} : '0;

    simon_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_round_count (r_round_count),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_cmd         (cmd)
    );

    simon_dp u_dp (
        .i_clk        (i_clk),
        .i_cmd        (cmd),
        .i_plain_x    (i_plain_x),
        .i_plain_y    (i_plain_y),
        .i_key_word_0 (i_key_word_0),
        .i_key_word_1 (i_key_word_1),
        .i_key_word_2 (i_key_word_2),
        .i_key_word_3 (i_key_word_3),
        .o_cipher_x   (o_cipher_x),
        .o_cipher_y   (o_cipher_y)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/simon_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Simon 128/256 controller
// Sequences load, round steps and result hand-off; owns both handshakes.
// ----------------------------------------------------------------------------
module simon_ctrl
    import simon_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [ROUND_W-1:0] i_round_count,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output t_dp_cmd                 o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_RUN   = 3'b010,
        S_DRAIN = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic [ROUND_W-1:0] r_left, n_left;
    logic               r_out_valid, n_out_valid;
    logic               out_free;
    logic               in_acc;
    t_state             load_state;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) || ((r_state == S_DRAIN) && out_free));
    assign in_acc     = i_in_valid && !o_in_stall;
    assign load_state = (i_round_count == '0) ? S_DRAIN : S_RUN;

    assign o_cmd.load    = in_acc;
    assign o_cmd.step    = (r_state == S_RUN);
    assign o_cmd.publish = (r_state == S_DRAIN) && out_free;

    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        n_left  = r_left;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = load_state;
                end
            end
            S_RUN: begin
                if (r_left == ROUND_W'(1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (out_free) begin
                    n_state = in_acc ? load_state : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (in_acc) begin
            n_left = i_round_count;
        end else if (r_state == S_RUN) begin
            n_left = r_left - ROUND_W'(1);
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.publish) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    a_no_accept_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> o_in_stall)
        else $error("input taken while rounds are running");

    a_run_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_left != '0))
        else $error("round counter empty while running");

    a_out_from_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DRAIN))
        else $error("result published outside drain");

    a_drain_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN && r_out_valid && i_out_stall) |=> (r_state == S_DRAIN))
        else $error("drain left while output register busy");

endmodule
`default_nettype wire

// ===== hw/rtl/simon_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Simon 128/256 datapath
// One shared round unit with an on-the-fly key window and an output register.
// ----------------------------------------------------------------------------
module simon_dp
    import simon_pkg::*;
(
    input  wire logic    i_clk,
    input  wire t_dp_cmd i_cmd,
    input  wire t_word   i_plain_x,
    input  wire t_word   i_plain_y,
    input  wire t_word   i_key_word_0,
    input  wire t_word   i_key_word_1,
    input  wire t_word   i_key_word_2,
    input  wire t_word   i_key_word_3,
    output t_word        o_cipher_x,
    output t_word        o_cipher_y
);

    t_word               r_x, r_y;
    t_word               r_w [4];
    logic [Z_IDX_W-1:0]  r_zi;
    t_word               r_out_x, r_out_y;
    t_word               key_new;

    assign key_new = simon_key_next(r_w[0], r_w[1], r_w[3], Z4_SEQ[r_zi]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x    <= i_plain_x;
            r_y    <= i_plain_y;
            r_w[0] <= i_key_word_0;
            r_w[1] <= i_key_word_1;
            r_w[2] <= i_key_word_2;
            r_w[3] <= i_key_word_3;
            r_zi   <= '0;
        end else if (i_cmd.step) begin
            r_x    <= r_y ^ simon_f(r_x) ^ r_w[0];
            r_y    <= r_x;
            // advance the key window by one round
            r_w[0] <= r_w[1];
            r_w[1] <= r_w[2];
            r_w[2] <= r_w[3];
            r_w[3] <= key_new;
            r_zi   <= (r_zi == Z_IDX_LAST) ? '0 : r_zi + Z_IDX_W'(1);
        end
        if (i_cmd.publish) begin
            r_out_x <= r_x;
            r_out_y <= r_y;
        end
    end

    assign o_cipher_x = r_out_x;
    assign o_cipher_y = r_out_y;

endmodule
`default_nettype wire
